/* hw/rtl/mibd_pkg.sv */
// Shared types, opcode constants and decode helpers for the MOV byte decoder.
// Used by the front, queue, back and top modules; depends on nothing.
package mibd_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   localparam logic [7:0] MASK_RM_REG   = 8'hFC;
   localparam logic [7:0] OP_RM_REG     = 8'h88;
   localparam logic [7:0] MASK_IMM_RM   = 8'hFE;
   localparam logic [7:0] OP_IMM_RM     = 8'hC6;
   localparam logic [7:0] MASK_IMM_REG  = 8'hF0;
   localparam logic [7:0] OP_IMM_REG    = 8'hB0;
   localparam logic [7:0] MASK_ACC_MEM  = 8'hFC;
   localparam logic [7:0] OP_ACC_MEM    = 8'hA0;
   localparam logic [2:0] RM_DIRECT     = 3'h6;

   localparam logic [1:0] MOD_NO_DISP   = 2'd0;
   localparam logic [1:0] MOD_DISP8     = 2'd1;
   localparam logic [1:0] MOD_DISP16    = 2'd2;

   typedef enum logic [1:0] {
      FORM_RM_REG  = 2'd0,
      FORM_IMM_RM  = 2'd1,
      FORM_IMM_REG = 2'd2,
      FORM_ACC_MEM = 2'd3
   } form_type;

   typedef enum logic [1:0] {
      PH_OPCODE = 2'd0,
      PH_MODRM  = 2'd1,
      PH_DATA   = 2'd2
   } phase_type;

   // One queued byte together with its classification as an opcode.
   typedef struct packed {
      logic [7:0] code_byte;
      form_type   form;
      logic       bad;
   } q_entry_type;

   typedef struct packed {
      logic [2:0] dstart;
      logic [2:0] total;
   } layout_type;

   typedef struct packed {
      logic [7:0]  first_byte;
      logic [1:0]  form;
      logic        bad_opcode;
      logic        direction;
      logic        wide;
      logic [1:0]  mode_bits;
      logic [2:0]  reg_field;
      logic [2:0]  rm_field;
      logic [15:0] displacement;
      logic [15:0] immediate;
      logic [15:0] direct_address;
      logic [2:0]  length;
   } rsp_type;

   function automatic q_entry_type classify(input logic [7:0] op);
      q_entry_type e;
      e.code_byte = op;
      e.bad       = 1'b0;
      e.form      = FORM_RM_REG;
      if ((op & MASK_RM_REG) == OP_RM_REG) begin
         e.form = FORM_RM_REG;
      end else if ((op & MASK_IMM_RM) == OP_IMM_RM) begin
         e.form = FORM_IMM_RM;
      end else if ((op & MASK_IMM_REG) == OP_IMM_REG) begin
         e.form = FORM_IMM_REG;
      end else if ((op & MASK_ACC_MEM) == OP_ACC_MEM) begin
         e.form = FORM_ACC_MEM;
      end else begin
         e.bad = 1'b1;
      end
      return e;
   endfunction

   function automatic logic [1:0] disp_len(input logic [7:0] modrm);
      logic [1:0] len;
      unique case (modrm[7:6])
         MOD_NO_DISP: len = (modrm[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
         MOD_DISP8:   len = 2'd1;
         MOD_DISP16:  len = 2'd2;
         default:     len = 2'd0;
      endcase
      return len;
   endfunction

   function automatic logic is_wide(input form_type form, input logic [7:0] op);
      return (form == FORM_IMM_REG) ? op[3] : op[0];
   endfunction

   function automatic layout_type layout(input form_type form, input logic [7:0] op,
                                         input logic [7:0] modrm);
      layout_type l;
      logic [2:0] w;
      w = is_wide(form, op) ? 3'd2 : 3'd1;
      unique case (form)
         FORM_RM_REG: begin
            l.dstart = 3'd2 + {1'b0, disp_len(modrm)};
            l.total  = l.dstart;
         end
         FORM_IMM_RM: begin
            l.dstart = 3'd2 + {1'b0, disp_len(modrm)};
            l.total  = l.dstart + w;
         end
         FORM_IMM_REG: begin
            l.dstart = 3'd1;
            l.total  = 3'd1 + w;
         end
         default: begin
            l.dstart = 3'd1;
            l.total  = 3'd3;
         end
      endcase
      return l;
   endfunction

endpackage

/* hw/rtl/mov_instruction_byte_decoder_top.sv */
// Top level of the 8086 MOV byte-stream decoder: front, queue and back end.
// Depends on mibd_pkg, mibd_front, mibd_queue and mibd_back.
//
//   Channel   Direction  Handshake           Payload
//   req_      in         req_valid/ready     req_code_byte (one code byte per request)
//   rsp_      out        rsp_valid/ready     decoded MOV fields, error flag and length
//
// The block takes one byte per cycle while the queue is not full. Each byte waits
// in the queue for the back end's assembly step, which registers the response, so
// a response appears the cycle after the queue hands over an instruction's last byte.
// Reset is synchronous and active high; it empties the queue, returns the decoder
// to the opcode phase and drops any pending response. A stalled response holds the
// back end, and the queue of QUEUE_DEPTH bytes keeps accepting requests until full.
module mov_instruction_byte_decoder_top #(
   parameter int QUEUE_DEPTH = mibd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_code_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_first_byte,
   output logic [1:0]  rsp_form,
   output logic        rsp_bad_opcode,
   output logic        rsp_direction,
   output logic        rsp_wide,
   output logic [1:0]  rsp_mode_bits,
   output logic [2:0]  rsp_reg_field,
   output logic [2:0]  rsp_rm_field,
   output logic [15:0] rsp_displacement,
   output logic [15:0] rsp_immediate,
   output logic [15:0] rsp_direct_address,
   output logic [2:0]  rsp_length
);
   import mibd_pkg::*;

   logic        q_full;
   logic        q_push;
   logic        q_pop;
   logic        q_not_empty;
   q_entry_type q_push_entry;
   q_entry_type q_head;
   rsp_type     rsp_data;

   // The front end classifies every byte as a possible opcode on the way in.
   mibd_front u_front (
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_code_byte (req_code_byte),
      .q_full        (q_full),
      .push          (q_push),
      .push_entry    (q_push_entry)
   );

   // The queue lets requests keep flowing while a response waits to be taken.
   mibd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .not_empty  (q_not_empty),
      .head_entry (q_head)
   );

   // The back end gathers ModR/M, displacement and data bytes and builds
   // one response per instruction, or one per unrecognized opcode.
   mibd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   assign rsp_first_byte     = rsp_data.first_byte;
   assign rsp_form           = rsp_data.form;
   assign rsp_bad_opcode     = rsp_data.bad_opcode;
   assign rsp_direction      = rsp_data.direction;
   assign rsp_wide           = rsp_data.wide;
   assign rsp_mode_bits      = rsp_data.mode_bits;
   assign rsp_reg_field      = rsp_data.reg_field;
   assign rsp_rm_field       = rsp_data.rm_field;
   assign rsp_displacement   = rsp_data.displacement;
   assign rsp_immediate      = rsp_data.immediate;
   assign rsp_direct_address = rsp_data.direct_address;
   assign rsp_length         = rsp_data.length;

endmodule

/* hw/rtl/mibd_front.sv */
// Front end: takes request bytes and tags each with its opcode classification.
// Depends on mibd_pkg; feeds mibd_queue.
module mibd_front (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_code_byte,
   input  logic                 q_full,
   output logic                 push,
   output mibd_pkg::q_entry_type push_entry
);
   import mibd_pkg::*;

   // Every byte is classified as though it were an opcode; the back end
   // uses the tag only when the byte really opens an instruction.
   assign req_ready  = !q_full;
   assign push       = req_valid && !q_full;
   assign push_entry = classify(req_code_byte);

endmodule

/* hw/rtl/mibd_queue.sv */
// Small FIFO of classified bytes between the front and back ends.
// Depends on mibd_pkg for the entry type.
module mibd_queue #(
   parameter int DEPTH = mibd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  mibd_pkg::q_entry_type push_entry,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output mibd_pkg::q_entry_type head_entry
);
   import mibd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   q_entry_type      slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = (count_ff == FULL_CNT);
   assign not_empty  = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* hw/rtl/mibd_back.sv */
// Back end: instruction assembly state machine and the response register.
// Depends on mibd_pkg; pops classified bytes from mibd_queue.
module mibd_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_not_empty,
   input  mibd_pkg::q_entry_type q_head,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output mibd_pkg::rsp_type     rsp_data
);
   import mibd_pkg::*;

   phase_type   phase_ff, phase_in;
   form_type    form_ff, form_in;
   logic [7:0]  opcode_ff, opcode_in;
   logic [7:0]  modrm_ff, modrm_in;
   logic [2:0]  taken_ff, taken_in;
   logic [15:0] disp_ff, disp_in;
   logic [15:0] data_ff, data_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        out_free;
   logic        emit;
   logic        emit_bad;
   layout_type  lay;
   logic        k;

   function automatic rsp_type build_result(input form_type form, input logic [7:0] op,
                                            input logic [7:0] m, input logic [15:0] disp,
                                            input logic [15:0] data, input logic [2:0] total);
      rsp_type    r;
      logic       w;
      logic [1:0] dl;
      w  = is_wide(form, op);
      dl = disp_len(m);
      r  = '0;
      r.first_byte = op;
      r.form       = form;
      r.wide       = w;
      r.length     = total;
      unique case (form)
         FORM_RM_REG, FORM_IMM_RM: begin
            r.direction = (form == FORM_RM_REG) ? op[1] : 1'b1;
            r.mode_bits = m[7:6];
            r.reg_field = m[5:3];
            r.rm_field  = m[2:0];
            if (dl == 2'd1) begin
               r.displacement = {{8{disp[7]}}, disp[7:0]};
            end else if (dl == 2'd2) begin
               r.displacement = disp;
            end
            if (form == FORM_IMM_RM) begin
               r.immediate = w ? data : {8'h00, data[7:0]};
            end
         end
         FORM_IMM_REG: begin
            r.direction = 1'b1;
            r.reg_field = op[2:0];
            r.immediate = w ? data : {8'h00, data[7:0]};
         end
         default: begin
            r.direction      = op[1];
            r.direct_address = data;
         end
      endcase
      return r;
   endfunction

   // A byte leaves the queue only when the response register can take
   // whatever it produces in the same cycle.
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pop      = q_not_empty && out_free;

   always_comb begin
      phase_in  = phase_ff;
      form_in   = form_ff;
      opcode_in = opcode_ff;
      modrm_in  = modrm_ff;
      taken_in  = taken_ff;
      disp_in   = disp_ff;
      data_in   = data_ff;
      emit      = 1'b0;
      emit_bad  = 1'b0;
      lay       = layout(form_ff, opcode_ff, modrm_ff);
      k         = 1'b0;
      if (pop) begin
         unique case (phase_ff)
            PH_MODRM: begin
               modrm_in = q_head.code_byte;
               taken_in = 3'd2;
               phase_in = PH_DATA;
               lay      = layout(form_ff, opcode_ff, q_head.code_byte);
               emit     = (lay.total <= 3'd2);
            end
            PH_DATA: begin
               if (taken_ff < lay.dstart) begin
                  k = taken_ff[0];
                  if (k) begin
                     disp_in[15:8] = disp_ff[15:8] | q_head.code_byte;
                  end else begin
                     disp_in[7:0] = disp_ff[7:0] | q_head.code_byte;
                  end
               end else begin
                  k = taken_ff[0] ^ lay.dstart[0];
                  if (k) begin
                     data_in[15:8] = data_ff[15:8] | q_head.code_byte;
                  end else begin
                     data_in[7:0] = data_ff[7:0] | q_head.code_byte;
                  end
               end
               taken_in = taken_ff + 3'd1;
               emit     = (taken_in >= lay.total);
            end
            default: begin
               if (q_head.bad) begin
                  emit_bad = 1'b1;
               end else begin
                  opcode_in = q_head.code_byte;
                  form_in   = q_head.form;
                  modrm_in  = '0;
                  taken_in  = 3'd1;
                  disp_in   = '0;
                  data_in   = '0;
                  phase_in  = (q_head.form == FORM_RM_REG || q_head.form == FORM_IMM_RM) ?
                              PH_MODRM : PH_DATA;
               end
            end
         endcase
         if (emit || emit_bad) begin
            phase_in = PH_OPCODE;
            taken_in = '0;
         end
      end

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (emit_bad) begin
         rsp_valid_in      = 1'b1;
         rsp_in            = '0;
         rsp_in.first_byte = q_head.code_byte;
         rsp_in.bad_opcode = 1'b1;
         rsp_in.length     = 3'd1;
      end else if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = build_result(form_ff, opcode_ff, modrm_in, disp_in, data_in,
                                     lay.total);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_OPCODE;
         taken_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         taken_ff     <= taken_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      form_ff   <= form_in;
      opcode_ff <= opcode_in;
      modrm_ff  <= modrm_in;
      disp_ff   <= disp_in;
      data_ff   <= data_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* sim/mov_instruction_byte_decoder_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for mov_instruction_byte_decoder_top: feeds 8086 code bytes
// and checks every decoded MOV response against a byte-level decode model kept here.
// Depends on mibd_pkg and mov_instruction_byte_decoder_top.
module mov_instruction_byte_decoder_top_tb;
   import mibd_pkg::*;

   // Run length and stall sizes. The cycle limit leaves a wide margin over the slowest
   // correct run, even with both sides idling.
   localparam int CYCLE_LIMIT      = 400000;
   localparam int RANDOM_BYTES     = 1450;
   localparam int LONG_HOLD_CYCLES = 200;
   localparam int DRAIN_CYCLES     = 20;

   logic        clock;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_ready;
   logic [7:0]  req_code_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready     = 1'b0;
   logic [7:0]  rsp_first_byte;
   logic [1:0]  rsp_form;
   logic        rsp_bad_opcode;
   logic        rsp_direction;
   logic        rsp_wide;
   logic [1:0]  rsp_mode_bits;
   logic [2:0]  rsp_reg_field;
   logic [2:0]  rsp_rm_field;
   logic [15:0] rsp_displacement;
   logic [15:0] rsp_immediate;
   logic [15:0] rsp_direct_address;
   logic [2:0]  rsp_length;

   mov_instruction_byte_decoder_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_code_byte      (req_code_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_first_byte     (rsp_first_byte),
      .rsp_form           (rsp_form),
      .rsp_bad_opcode     (rsp_bad_opcode),
      .rsp_direction      (rsp_direction),
      .rsp_wide           (rsp_wide),
      .rsp_mode_bits      (rsp_mode_bits),
      .rsp_reg_field      (rsp_reg_field),
      .rsp_rm_field       (rsp_rm_field),
      .rsp_displacement   (rsp_displacement),
      .rsp_immediate      (rsp_immediate),
      .rsp_direct_address (rsp_direct_address),
      .rsp_length         (rsp_length)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Decoder state as the testbench sees it. It advances once per accepted request,
   // so the expected responses are ready long before the block produces them.
   phase_type   dec_phase  = PH_OPCODE;
   logic [7:0]  dec_opcode = 8'h00;
   logic [7:0]  dec_modrm  = 8'h00;
   logic [2:0]  dec_count  = 3'd0;
   logic [15:0] dec_disp   = 16'h0000;
   logic [15:0] dec_data   = 16'h0000;

   rsp_type pending_decodes[$];   // decoded instructions not yet seen on rsp_
   int      error_count  = 0;
   int      cycle_count  = 0;
   int      bytes_sent   = 0;
   bit      idling_on    = 1'b1;  // random gaps on both channels
   bit      hold_off_pending = 1'b0;
   int      hold_left    = 0;
   int      stall_left   = 0;

   // Returns 1 and the form when the opcode is one of the four supported MOV forms.
   function automatic bit mov_form(input logic [7:0] op, output form_type f);
      f = FORM_RM_REG;
      if ((op & MASK_RM_REG) == OP_RM_REG) f = FORM_RM_REG;
      else if ((op & MASK_IMM_RM) == OP_IMM_RM) f = FORM_IMM_RM;
      else if ((op & MASK_IMM_REG) == OP_IMM_REG) f = FORM_IMM_REG;
      else if ((op & MASK_ACC_MEM) == OP_ACC_MEM) f = FORM_ACC_MEM;
      else return 1'b0;
      return 1'b1;
   endfunction

   // Number of displacement bytes that follow a mod-reg-rm byte.
   function automatic int disp_bytes(input logic [7:0] modrm);
      case (modrm[7:6])
         MOD_NO_DISP: return (modrm[2:0] == RM_DIRECT) ? 2 : 0;
         MOD_DISP8:   return 1;
         MOD_DISP16:  return 2;
         default:     return 0;
      endcase
   endfunction

   function automatic bit word_op(input form_type f, input logic [7:0] op);
      return (f == FORM_IMM_REG) ? op[3] : op[0];
   endfunction

   // Byte offset where immediate or address data starts, and the full length.
   function automatic void instr_shape(input form_type f, input logic [7:0] op,
                                       input logic [7:0] modrm,
                                       output int data_at, output int total);
      int w;
      w = word_op(f, op) ? 2 : 1;
      case (f)
         FORM_RM_REG: begin
            data_at = 2 + disp_bytes(modrm);
            total   = data_at;
         end
         FORM_IMM_RM: begin
            data_at = 2 + disp_bytes(modrm);
            total   = data_at + w;
         end
         FORM_IMM_REG: begin
            data_at = 1;
            total   = 1 + w;
         end
         default: begin
            data_at = 1;
            total   = 3;
         end
      endcase
   endfunction

   // Advances the decode state by one code byte. Returns 1 when the byte closes an
   // instruction (or is a bad opcode), with the response that it must produce.
   function automatic bit decode_byte(input logic [7:0] b, output rsp_type r);
      form_type f;
      int       data_at, total, k;
      bit       w;
      r = '0;
      if (dec_phase == PH_OPCODE) begin
         if (!mov_form(b, f)) begin
            // A bad opcode is answered at once and the next byte is an opcode again.
            r.first_byte = b;
            r.bad_opcode = 1'b1;
            r.length     = 3'd1;
            return 1'b1;
         end
         dec_opcode = b;
         dec_modrm  = 8'h00;
         dec_count  = 3'd1;
         dec_disp   = 16'h0000;
         dec_data   = 16'h0000;
         dec_phase  = (f == FORM_RM_REG || f == FORM_IMM_RM) ? PH_MODRM : PH_DATA;
         return 1'b0;
      end
      void'(mov_form(dec_opcode, f));
      if (dec_phase == PH_MODRM) begin
         dec_modrm = b;
         dec_count = 3'd2;
         dec_phase = PH_DATA;
      end else begin
         instr_shape(f, dec_opcode, dec_modrm, data_at, total);
         if (int'(dec_count) < data_at) begin
            k = (int'(dec_count) - 2) & 1;
            dec_disp = dec_disp | (16'(b) << (8 * k));
         end else begin
            k = (int'(dec_count) - data_at) & 1;
            dec_data = dec_data | (16'(b) << (8 * k));
         end
         dec_count = dec_count + 3'd1;
      end
      instr_shape(f, dec_opcode, dec_modrm, data_at, total);
      if (int'(dec_count) < total) return 1'b0;

      w = word_op(f, dec_opcode);
      r.first_byte = dec_opcode;
      r.form       = f;
      r.wide       = w;
      case (f)
         FORM_RM_REG, FORM_IMM_RM: begin
            r.direction = (f == FORM_RM_REG) ? dec_opcode[1] : 1'b1;
            r.mode_bits = dec_modrm[7:6];
            r.reg_field = dec_modrm[5:3];
            r.rm_field  = dec_modrm[2:0];
            // An 8-bit displacement is sign-extended; mod 3 and plain mod 0 have none.
            case (disp_bytes(dec_modrm))
               1:       r.displacement = {{8{dec_disp[7]}}, dec_disp[7:0]};
               2:       r.displacement = dec_disp;
               default: r.displacement = 16'h0000;
            endcase
            if (f == FORM_IMM_RM) r.immediate = w ? dec_data : {8'h00, dec_data[7:0]};
         end
         FORM_IMM_REG: begin
            r.direction = 1'b1;
            r.reg_field = dec_opcode[2:0];
            r.immediate = w ? dec_data : {8'h00, dec_data[7:0]};
         end
         default: begin
            r.direction      = dec_opcode[1];
            r.direct_address = dec_data;
         end
      endcase
      r.length  = 3'(total);
      dec_phase = PH_OPCODE;
      dec_count = 3'd0;
      return 1'b1;
   endfunction

   // Offers one code byte and waits for it to be taken. Valid is only lowered at the
   // start of an idle burst, so back-to-back requests keep it high without a glitch.
   task automatic send_code_byte(input logic [7:0] code);
      rsp_type decoded;
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_code_byte <= code;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
      if (decode_byte(code, decoded)) pending_decodes.push_back(decoded);
   endtask

   // Sends one whole instruction: opcode, then mod-reg-rm, displacement and data
   // bytes as its form calls for, all little endian. A bad opcode is sent alone.
   task automatic send_mov(input logic [7:0] op, input logic [7:0] modrm,
                           input logic [15:0] disp, input logic [15:0] data);
      form_type f;
      int       data_at, total, i;
      send_code_byte(op);
      if (!mov_form(op, f)) return;
      instr_shape(f, op, modrm, data_at, total);
      if (f == FORM_RM_REG || f == FORM_IMM_RM) begin
         send_code_byte(modrm);
         for (i = 0; i < data_at - 2; i++) send_code_byte(disp[8*i +: 8]);
      end
      for (i = 0; i < total - data_at; i++) send_code_byte(data[8*i +: 8]);
   endtask

   // Finishes whatever instruction a stray byte has opened, with random filler.
   task automatic sync_to_opcode();
      while (dec_phase != PH_OPCODE) send_code_byte(8'($urandom));
   endtask

   task automatic send_random_mov();
      logic [7:0] op;
      case ($urandom_range(0, 3))
         0:       op = OP_RM_REG  | 8'($urandom_range(0, 3));
         1:       op = OP_IMM_RM  | 8'($urandom_range(0, 1));
         2:       op = OP_IMM_REG | 8'($urandom_range(0, 15));
         default: op = OP_ACC_MEM | 8'($urandom_range(0, 3));
      endcase
      send_mov(op, 8'($urandom), 16'($urandom), 16'($urandom));
   endtask

   // Register to or from register/memory: every mod, direct address, disp8 of both signs.
   task automatic test_rm_reg_forms();
      sync_to_opcode();
      send_mov(8'h89, 8'hC1, 16'h0000, 16'h0000);
      send_mov(8'h8A, 8'h07, 16'h0000, 16'h0000);
      send_mov(8'h8B, 8'h2E, 16'hFFFF, 16'h0000);
      send_mov(8'h88, 8'h47, 16'h0080, 16'h0000);
      send_mov(8'h8B, 8'h7F, 16'h007F, 16'h0000);
      send_mov(8'h88, 8'hBD, 16'h1234, 16'h0000);
   endtask

   // Immediate to register/memory, including mod 3, which still carries its data.
   task automatic test_imm_to_rm();
      sync_to_opcode();
      send_mov(8'hC6, 8'hC3, 16'h0000, 16'h00FF);
      send_mov(8'hC7, 8'h80, 16'hFFFF, 16'h0000);
      send_mov(8'hC6, 8'h06, 16'h00FF, 16'h0080);
      send_mov(8'hC7, 8'h42, 16'h0080, 16'hABCD);
   endtask

   task automatic test_imm_to_reg();
      sync_to_opcode();
      send_mov(8'hB0, 8'h00, 16'h0000, 16'h0000);
      send_mov(8'hBF, 8'h00, 16'h0000, 16'hFFFF);
      send_mov(8'hB7, 8'h00, 16'h0000, 16'h00FF);
      send_mov(8'hB8, 8'h00, 16'h0000, 16'h0100);
   endtask

   // Accumulator forms in both directions and both widths.
   task automatic test_accumulator();
      sync_to_opcode();
      send_mov(8'hA0, 8'h00, 16'h0000, 16'h0000);
      send_mov(8'hA3, 8'h00, 16'h0000, 16'hFFFF);
      send_mov(8'hA1, 8'h00, 16'h0000, 16'h5AA5);
      send_mov(8'hA2, 8'h00, 16'h0000, 16'h8001);
   endtask

   // Bytes at the edges of the opcode space and just outside the 88, C6 and A0 patterns.
   task automatic test_bad_opcodes();
      sync_to_opcode();
      send_mov(8'h00, 8'h00, 16'h0000, 16'h0000);
      send_mov(8'hFF, 8'h00, 16'h0000, 16'h0000);
      send_mov(8'h8C, 8'h00, 16'h0000, 16'h0000);
      send_mov(8'hC5, 8'h00, 16'h0000, 16'h0000);
      send_mov(8'hA4, 8'h00, 16'h0000, 16'h0000);
   endtask

   // Mostly well-formed instructions with random content; the rest are stray bytes,
   // which may be bad opcodes or open an instruction that later bytes complete.
   task automatic test_random_stream();
      while (bytes_sent < RANDOM_BYTES) begin
         if ($urandom_range(0, 99) < 85) begin
            sync_to_opcode();
            send_random_mov();
         end else begin
            send_code_byte(8'($urandom));
         end
      end
   endtask

   // The receiver holds off for a long stretch while requests keep coming, so the
   // byte queue fills and req_ready has to drop until the responses drain.
   task automatic test_backpressure();
      int n;
      sync_to_opcode();
      hold_off_pending = 1'b1;
      for (n = 0; n < 25; n++) send_random_mov();
   endtask

   // Full rate on both sides to close out the run.
   task automatic test_quiet_tail();
      int n;
      idling_on = 1'b0;
      sync_to_opcode();
      for (n = 0; n < 15; n++) send_random_mov();
   endtask

   // The receiver: random stall bursts, plus the long hold-off that the backpressure
   // test asks for, counted down here.
   always @(posedge clock) begin
      if (hold_off_pending) begin
         hold_off_pending = 1'b0;
         hold_left        = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         error_count++;
         if (error_count <= 10)
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
      end
   endtask

   // Every response taken is matched against the oldest pending decode, field by field.
   always @(posedge clock) begin : response_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_decodes.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("%0t: response with nothing pending, first byte %h",
                        $time, rsp_first_byte);
         end else begin
            want = pending_decodes.pop_front();
            check_field("first_byte",     16'(want.first_byte),     16'(rsp_first_byte));
            check_field("form",           16'(want.form),           16'(rsp_form));
            check_field("bad_opcode",     16'(want.bad_opcode),     16'(rsp_bad_opcode));
            check_field("direction",      16'(want.direction),      16'(rsp_direction));
            check_field("wide",           16'(want.wide),           16'(rsp_wide));
            check_field("mode_bits",      16'(want.mode_bits),      16'(rsp_mode_bits));
            check_field("reg_field",      16'(want.reg_field),      16'(rsp_reg_field));
            check_field("rm_field",       16'(want.rm_field),       16'(rsp_rm_field));
            check_field("displacement",   want.displacement,        rsp_displacement);
            check_field("immediate",      want.immediate,           rsp_immediate);
            check_field("direct_address", want.direct_address,      rsp_direct_address);
            check_field("length",         16'(want.length),         16'(rsp_length));
         end
      end
   end

   // Watchdog: a hung handshake or a lost response ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("mov_instruction_byte_decoder_top regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_rm_reg_forms();
      test_imm_to_rm();
      test_imm_to_reg();
      test_accumulator();
      test_bad_opcodes();
      test_random_stream();
      test_backpressure();
      test_quiet_tail();

      // All requests are in; wait for the last responses, then a short quiet spell
      // so that any extra response would still be caught.
      req_valid <= 1'b0;
      while (pending_decodes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("mov_instruction_byte_decoder_top regression: pass");
      end else begin
         $display("mov_instruction_byte_decoder_top regression: fail");
      end
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/mibd_pkg.sv
hw/rtl/mibd_front.sv
hw/rtl/mibd_queue.sv
hw/rtl/mibd_back.sv
hw/rtl/mov_instruction_byte_decoder_top.sv
sim/mov_instruction_byte_decoder_top_tb.sv
